// ===== hdl/fsc_pkg.sv =====
// Shared constants, codes and types of the frustum sphere culling block.
package fsc_pkg;

	// Default sizes handed to the top level parameters.
	localparam int NumPlanesDef  = 6;
	localparam int MaxVisibleDef = 65536;

	// Field widths.
	localparam int CoordW  = 24;  // Q15.8 positions and plane constants
	localparam int NormW   = 16;  // Q1.14 normals
	localparam int LenW    = 23;  // unsigned Q15.8 radius, height and range
	localparam int ColorW  = 24;
	localparam int CapW    = 17;  // capacity register and visible counter
	localparam int SlotW   = 16;
	localparam int PlaneIdxW = 3;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 24;

	// Internal widths.
	localparam int CenterW = CoordW + 2;      // sphere center in Q.9
	localparam int DiffW   = CoordW + 3;      // center minus camera in Q.9
	localparam int SqW     = 2 * DiffW;       // one squared axis distance
	localparam int Dist2W  = SqW + 2;         // sum of three squares
	localparam int RangeW  = LenW + 1;        // doubled view range in Q.9
	localparam int Range2W = 2 * RangeW;      // squared view range
	localparam int ProdW   = NormW + CenterW; // normal times center, Q.23
	localparam int LaneW   = 48;              // plane distance sum, Q.23
	localparam int NormShift = 15;            // Q.8 to Q.23 through the 2^15 scale

	// 0.45 as 115/256 for the enlarged radius.
	localparam int HalfRadW = 30;
	localparam logic [6:0] HalfRadScale = 7'd115;
	localparam logic [LenW-1:0] MinRange = LenW'(256); // 1.0 in Q15.8

	// Item modes.
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_TEST  = 2'd2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_CAMERA_X  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CAMERA_Y  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CAMERA_Z  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_VIEW_DIST = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CAPACITY  = 3'd4;

	// Reset values of the range and capacity registers.
	localparam logic [LenW-1:0] ViewDistReset = LenW'(65536);
	localparam logic [CapW-1:0] CapacityReset = CapW'(65536);

	// Control of one plane lane for the first pipeline step.
	typedef struct packed {
		logic wr;   // load this lane's plane from the item in stage one
		logic adv;  // stage one item moves into stage two
	} fsc_lane_ctl_t;

	// Item in the last stage as seen by the counter and output register.
	typedef struct packed {
		logic       valid;
		logic [1:0] mode;
		logic       pass;
	} fsc_s3_t;

endpackage

// ===== hdl/frustum_sphere_cull.sv =====
// Top level of the frustum sphere culling pipeline.
//
// The block takes one beat per clock while in_ready is high and needs no
// clearing pass after reset. Each beat runs through four register stages:
// the input register, the product stage (one multiplier per axis for the
// range test and per plane component, plus the height scaling for the
// enlarged radius), the decision stage that sums the products and compares,
// and the result register, which drives out_valid for a kept instance. The
// only state carried from one beat to the next is the visible counter in the
// last stage, which is updated as a beat leaves it, so back to back beats
// keep a rate of one per cycle while nothing stalls. Each stage has its own
// valid bit and moves when the stage after it is empty or moving, so dropped
// instances, plane loads and count clears drain even while a result waits to
// be taken; in_ready falls only when every stage and the result register are
// full and out_ready is low. Plane loads are applied in order with the tests,
// so a test sees every plane loaded by earlier beats. Configuration writes
// take effect at once and are meant for an idle block.
module frustum_sphere_cull #(
	parameter int NUM_PLANES  = fsc_pkg::NumPlanesDef,
	parameter int MAX_VISIBLE = fsc_pkg::MaxVisibleDef
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration write port.
	input  logic                                   cfg_we,
	input  logic        [fsc_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic        [fsc_pkg::CfgDataW-1:0]    cfg_data,
	// Input channel.
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic        [1:0]                      mode,
	input  logic        [fsc_pkg::PlaneIdxW-1:0]   plane_index,
	input  logic signed [fsc_pkg::NormW-1:0]       normal_x,
	input  logic signed [fsc_pkg::NormW-1:0]       normal_y,
	input  logic signed [fsc_pkg::NormW-1:0]       normal_z,
	input  logic signed [fsc_pkg::CoordW-1:0]      plane_offset,
	input  logic signed [fsc_pkg::CoordW-1:0]      base_x,
	input  logic signed [fsc_pkg::CoordW-1:0]      base_y,
	input  logic signed [fsc_pkg::CoordW-1:0]      base_z,
	input  logic        [fsc_pkg::LenW-1:0]        radius,
	input  logic        [fsc_pkg::LenW-1:0]        height,
	input  logic        [fsc_pkg::ColorW-1:0]      color,
	// Result channel.
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [fsc_pkg::SlotW-1:0]       slot,
	output logic signed [fsc_pkg::CoordW-1:0]      out_base_x,
	output logic signed [fsc_pkg::CoordW-1:0]      out_base_y,
	output logic signed [fsc_pkg::CoordW-1:0]      out_base_z,
	output logic        [fsc_pkg::LenW-1:0]        out_radius,
	output logic        [fsc_pkg::LenW-1:0]        out_height,
	output logic        [fsc_pkg::ColorW-1:0]      out_color,
	output logic                                   full_res
);

	// Configuration registers.
	logic signed [fsc_pkg::CoordW-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic        [fsc_pkg::LenW-1:0]   view_dist_q;
	logic        [fsc_pkg::CapW-1:0]   capacity_q;
	logic        [fsc_pkg::CapW-1:0]   eff_cap;

	// Stage one: the accepted beat as it arrived.
	logic                                 valid_s1;
	logic        [1:0]                    mode_s1;
	logic        [fsc_pkg::PlaneIdxW-1:0] plane_index_s1;
	logic signed [fsc_pkg::NormW-1:0]     normal_x_s1, normal_y_s1, normal_z_s1;
	logic signed [fsc_pkg::CoordW-1:0]    plane_offset_s1;
	logic signed [fsc_pkg::CoordW-1:0]    base_x_s1, base_y_s1, base_z_s1;
	logic        [fsc_pkg::LenW-1:0]      radius_s1, height_s1;
	logic        [fsc_pkg::ColorW-1:0]    color_s1;

	// Stage two: products are held inside the lanes and the range unit.
	logic                                 valid_s2;
	logic        [1:0]                    mode_s2;
	logic signed [fsc_pkg::CoordW-1:0]    base_x_s2, base_y_s2, base_z_s2;
	logic        [fsc_pkg::LenW-1:0]      radius_s2, height_s2, r_s2;
	logic        [fsc_pkg::ColorW-1:0]    color_s2;

	// Stage three: the decision, waiting for the counter.
	logic                                 valid_s3;
	logic        [1:0]                    mode_s3;
	logic                                 pass_s3;
	logic signed [fsc_pkg::CoordW-1:0]    base_x_s3, base_y_s3, base_z_s3;
	logic        [fsc_pkg::LenW-1:0]      radius_s3, height_s3;
	logic        [fsc_pkg::ColorW-1:0]    color_s3;

	logic rdy_s1, rdy_s2, rdy_s3;
	logic move_s1, move_s2;

	logic signed [fsc_pkg::CenterW-1:0] cx, cy, cz;
	logic        [fsc_pkg::HalfRadW-1:0] hgt_scaled;
	logic        [fsc_pkg::LenW-1:0]     hgt_rad;
	logic        [fsc_pkg::LenW-1:0]     r_big;

	fsc_pkg::fsc_lane_ctl_t  lane_ctl [NUM_PLANES];
	logic [NUM_PLANES-1:0]   lane_ok;
	logic                    dist_ok;
	fsc_pkg::fsc_s3_t        s3;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q     <= '0;
			cam_y_q     <= '0;
			cam_z_q     <= '0;
			view_dist_q <= fsc_pkg::ViewDistReset;
			capacity_q  <= fsc_pkg::CapacityReset;
		end else if (cfg_we) begin
			case (cfg_index)
				fsc_pkg::REG_CAMERA_X:  cam_x_q     <= $signed(cfg_data[fsc_pkg::CoordW-1:0]);
				fsc_pkg::REG_CAMERA_Y:  cam_y_q     <= $signed(cfg_data[fsc_pkg::CoordW-1:0]);
				fsc_pkg::REG_CAMERA_Z:  cam_z_q     <= $signed(cfg_data[fsc_pkg::CoordW-1:0]);
				fsc_pkg::REG_VIEW_DIST: view_dist_q <= cfg_data[fsc_pkg::LenW-1:0];
				fsc_pkg::REG_CAPACITY:  capacity_q  <= cfg_data[fsc_pkg::CapW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective capacity: at least one, at most the visible list size.
	always_comb begin
		eff_cap = capacity_q;
		if (eff_cap == '0) begin
			eff_cap = fsc_pkg::CapW'(1);
		end
		if (32'(eff_cap) > 32'(MAX_VISIBLE)) begin
			eff_cap = fsc_pkg::CapW'(MAX_VISIBLE);
		end
	end

	// ------------------------------------------------------------------
	// Stage handshakes. Each stage takes a new beat when it is empty or
	// its occupant moves on.
	// ------------------------------------------------------------------
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign move_s1  = valid_s1 && rdy_s2;
	assign move_s2  = valid_s2 && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			mode_s1         <= mode;
			plane_index_s1  <= plane_index;
			normal_x_s1     <= normal_x;
			normal_y_s1     <= normal_y;
			normal_z_s1     <= normal_z;
			plane_offset_s1 <= plane_offset;
			base_x_s1       <= base_x;
			base_y_s1       <= base_y;
			base_z_s1       <= base_z;
			radius_s1       <= radius;
			height_s1       <= height;
			color_s1        <= color;
		end
		if (move_s1) begin
			mode_s2   <= mode_s1;
			base_x_s2 <= base_x_s1;
			base_y_s2 <= base_y_s1;
			base_z_s2 <= base_z_s1;
			radius_s2 <= radius_s1;
			height_s2 <= height_s1;
			color_s2  <= color_s1;
			r_s2      <= r_big;
		end
		if (move_s2) begin
			mode_s3   <= mode_s2;
			pass_s3   <= dist_ok && (&lane_ok);
			base_x_s3 <= base_x_s2;
			base_y_s3 <= base_y_s2;
			base_z_s3 <= base_z_s2;
			radius_s3 <= radius_s2;
			height_s3 <= height_s2;
			color_s3  <= color_s2;
		end
	end

	// ------------------------------------------------------------------
	// Bounding sphere. The center is kept in Q.9 so that half the height
	// is exact; the radius grows to 0.45 of the height when that is larger.
	// ------------------------------------------------------------------
	assign cx = fsc_pkg::CenterW'(base_x_s1) <<< 1;
	assign cz = fsc_pkg::CenterW'(base_z_s1) <<< 1;
	assign cy = (fsc_pkg::CenterW'(base_y_s1) <<< 1)
		+ fsc_pkg::CenterW'($signed({1'b0, height_s1}));

	assign hgt_scaled = fsc_pkg::HalfRadW'(height_s1) * fsc_pkg::HalfRadW'(fsc_pkg::HalfRadScale);
	assign hgt_rad    = fsc_pkg::LenW'(hgt_scaled[fsc_pkg::HalfRadW-1:8]);
	assign r_big      = (radius_s1 > hgt_rad) ? radius_s1 : hgt_rad;

	// ------------------------------------------------------------------
	// Plane lanes. A load with an index past the last plane matches no lane
	// and is dropped.
	// ------------------------------------------------------------------
	for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
		assign lane_ctl[g].wr  = move_s1 && (mode_s1 == fsc_pkg::MODE_LOAD)
			&& (plane_index_s1 == fsc_pkg::PlaneIdxW'(g));
		assign lane_ctl[g].adv = move_s1;

		fsc_plane_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl[g]),
			.wr_nx  (normal_x_s1),
			.wr_ny  (normal_y_s1),
			.wr_nz  (normal_z_s1),
			.wr_off (plane_offset_s1),
			.cx     (cx),
			.cy     (cy),
			.cz     (cz),
			.r_s2   (r_s2),
			.ok     (lane_ok[g])
		);
	end

	fsc_dist u_dist (
		.clk       (clk),
		.adv       (move_s1),
		.cx        (cx),
		.cy        (cy),
		.cz        (cz),
		.cam_x     (cam_x_q),
		.cam_y     (cam_y_q),
		.cam_z     (cam_z_q),
		.view_dist (view_dist_q),
		.dist_ok   (dist_ok)
	);

	// ------------------------------------------------------------------
	// Counter and result register.
	// ------------------------------------------------------------------
	assign s3.valid = valid_s3;
	assign s3.mode  = mode_s3;
	assign s3.pass  = pass_s3;

	fsc_tally u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.s3         (s3),
		.cap        (eff_cap),
		.base_x_s3  (base_x_s3),
		.base_y_s3  (base_y_s3),
		.base_z_s3  (base_z_s3),
		.radius_s3  (radius_s3),
		.height_s3  (height_s3),
		.color_s3   (color_s3),
		.rdy_s3     (rdy_s3),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot       (slot),
		.out_base_x (out_base_x),
		.out_base_y (out_base_y),
		.out_base_z (out_base_z),
		.out_radius (out_radius),
		.out_height (out_height),
		.out_color  (out_color),
		.full_res   (full_res)
	);

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// A new result only comes from a passing test beat in the last stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s3 && (mode_s3 == fsc_pkg::MODE_TEST) && pass_s3))
		else $error("result without a passing test beat");

	// The full flag is only raised on the slot that reaches the capacity.
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && full_res) |-> ((fsc_pkg::CapW'(slot) + fsc_pkg::CapW'(1)) == eff_cap))
		else $error("full flag does not match slot and capacity");

	// Input backpressure only when every stage and the result are occupied.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3 && out_valid && !out_ready))
		else $error("input stalled with room in the pipeline");

endmodule

// ===== hdl/fsc_plane_lane.sv =====
// One frustum plane: its stored plane, registered products and the side test.
module fsc_plane_lane (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fsc_pkg::fsc_lane_ctl_t                 ctl,
	input  logic signed [fsc_pkg::NormW-1:0]       wr_nx,
	input  logic signed [fsc_pkg::NormW-1:0]       wr_ny,
	input  logic signed [fsc_pkg::NormW-1:0]       wr_nz,
	input  logic signed [fsc_pkg::CoordW-1:0]      wr_off,
	input  logic signed [fsc_pkg::CenterW-1:0]     cx,
	input  logic signed [fsc_pkg::CenterW-1:0]     cy,
	input  logic signed [fsc_pkg::CenterW-1:0]     cz,
	input  logic        [fsc_pkg::LenW-1:0]        r_s2,
	output logic                                   ok
);

	logic signed [fsc_pkg::NormW-1:0]  nx_q, ny_q, nz_q;
	logic signed [fsc_pkg::CoordW-1:0] off_q;
	logic signed [fsc_pkg::ProdW-1:0]  px_s2, py_s2, pz_s2;
	logic signed [fsc_pkg::CoordW-1:0] off_s2;
	logic signed [fsc_pkg::LaneW-1:0]  sum;

	// A plane left at reset has zero normal and offset and never rejects.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q  <= '0;
			ny_q  <= '0;
			nz_q  <= '0;
			off_q <= '0;
		end else if (ctl.wr) begin
			nx_q  <= wr_nx;
			ny_q  <= wr_ny;
			nz_q  <= wr_nz;
			off_q <= wr_off;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			px_s2  <= nx_q * cx;
			py_s2  <= ny_q * cy;
			pz_s2  <= nz_q * cz;
			off_s2 <= off_q;
		end
	end

	// n.c + d >= -r, written as n.c + d + r >= 0, all in Q.23.
	assign sum = fsc_pkg::LaneW'(px_s2) + fsc_pkg::LaneW'(py_s2) + fsc_pkg::LaneW'(pz_s2)
		+ (fsc_pkg::LaneW'(off_s2) <<< fsc_pkg::NormShift)
		+ (fsc_pkg::LaneW'($signed({1'b0, r_s2})) <<< fsc_pkg::NormShift);
	assign ok = !sum[fsc_pkg::LaneW-1];

endmodule

// ===== hdl/fsc_dist.sv =====
// Range test: registered squared distances to the camera and the compare.
module fsc_dist (
	input  logic                                   clk,
	input  logic                                   adv,
	input  logic signed [fsc_pkg::CenterW-1:0]     cx,
	input  logic signed [fsc_pkg::CenterW-1:0]     cy,
	input  logic signed [fsc_pkg::CenterW-1:0]     cz,
	input  logic signed [fsc_pkg::CoordW-1:0]      cam_x,
	input  logic signed [fsc_pkg::CoordW-1:0]      cam_y,
	input  logic signed [fsc_pkg::CoordW-1:0]      cam_z,
	input  logic        [fsc_pkg::LenW-1:0]        view_dist,
	output logic                                   dist_ok
);

	logic signed [fsc_pkg::DiffW-1:0]   dx, dy, dz;
	logic        [fsc_pkg::LenW-1:0]    range_c;
	logic        [fsc_pkg::RangeW-1:0]  range2x;
	logic signed [fsc_pkg::SqW-1:0]     sq_x_s2, sq_y_s2, sq_z_s2;
	logic        [fsc_pkg::Range2W-1:0] range_sq_s2;
	logic signed [fsc_pkg::Dist2W-1:0]  d2;

	// Camera is doubled into the Q.9 grid of the center.
	assign dx = fsc_pkg::DiffW'(cx) - (fsc_pkg::DiffW'(cam_x) <<< 1);
	assign dy = fsc_pkg::DiffW'(cy) - (fsc_pkg::DiffW'(cam_y) <<< 1);
	assign dz = fsc_pkg::DiffW'(cz) - (fsc_pkg::DiffW'(cam_z) <<< 1);

	// The visible range never drops below 1.0.
	assign range_c = (view_dist < fsc_pkg::MinRange) ? fsc_pkg::MinRange : view_dist;
	assign range2x = {range_c, 1'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s2     <= dx * dx;
			sq_y_s2     <= dy * dy;
			sq_z_s2     <= dz * dz;
			range_sq_s2 <= fsc_pkg::Range2W'(range2x) * fsc_pkg::Range2W'(range2x);
		end
	end

	assign d2 = fsc_pkg::Dist2W'(sq_x_s2) + fsc_pkg::Dist2W'(sq_y_s2)
		+ fsc_pkg::Dist2W'(sq_z_s2);
	assign dist_ok = d2 <= $signed(fsc_pkg::Dist2W'({1'b0, range_sq_s2}));

endmodule

// ===== hdl/fsc_tally.sv =====
// Visible counter, capacity check and the result register.
module fsc_tally (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fsc_pkg::fsc_s3_t                       s3,
	input  logic        [fsc_pkg::CapW-1:0]        cap,
	input  logic signed [fsc_pkg::CoordW-1:0]      base_x_s3,
	input  logic signed [fsc_pkg::CoordW-1:0]      base_y_s3,
	input  logic signed [fsc_pkg::CoordW-1:0]      base_z_s3,
	input  logic        [fsc_pkg::LenW-1:0]        radius_s3,
	input  logic        [fsc_pkg::LenW-1:0]        height_s3,
	input  logic        [fsc_pkg::ColorW-1:0]      color_s3,
	output logic                                   rdy_s3,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [fsc_pkg::SlotW-1:0]       slot,
	output logic signed [fsc_pkg::CoordW-1:0]      out_base_x,
	output logic signed [fsc_pkg::CoordW-1:0]      out_base_y,
	output logic signed [fsc_pkg::CoordW-1:0]      out_base_z,
	output logic        [fsc_pkg::LenW-1:0]        out_radius,
	output logic        [fsc_pkg::LenW-1:0]        out_height,
	output logic        [fsc_pkg::ColorW-1:0]      out_color,
	output logic                                   full_res
);

	logic [fsc_pkg::CapW-1:0] count_q;
	logic [fsc_pkg::CapW-1:0] count_inc;
	logic                     out_valid_q;
	logic                     out_free;
	logic                     keep;
	logic                     leave;

	assign count_inc = count_q + fsc_pkg::CapW'(1);
	assign out_free  = !out_valid_q || out_ready;
	assign keep      = s3.valid && (s3.mode == fsc_pkg::MODE_TEST) && s3.pass
		&& (count_q < cap);
	// A dropped item leaves even while a result waits.
	assign rdy_s3    = !keep || out_free;
	assign leave     = s3.valid && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (leave && (s3.mode == fsc_pkg::MODE_CLEAR)) begin
				count_q <= '0;
			end else if (keep && out_free) begin
				count_q <= count_inc;
			end
			if (out_free) begin
				out_valid_q <= keep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keep && out_free) begin
			slot       <= count_q[fsc_pkg::SlotW-1:0];
			out_base_x <= base_x_s3;
			out_base_y <= base_y_s3;
			out_base_z <= base_z_s3;
			out_radius <= radius_s3;
			out_height <= height_s3;
			out_color  <= color_s3;
			full_res   <= (count_inc == cap);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the frustum sphere culling block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fsc_pkg::*;

	localparam int NUM_PL = NumPlanesDef;
	localparam int MAX_VIS = MaxVisibleDef;

	// Mode 3 has no meaning; the block must swallow it silently.
	localparam logic [1:0] ModeUnused = 2'd3;

	localparam int NumPhases = 10;
	localparam int ItemsPerPhase = 30;
	// A beat still crosses the pipeline registers after acceptance; allow a
	// margin before touching the registers or ending the run.
	localparam int DrainCycles = 8;
	localparam int CycleLimit = 300000;

	// One input beat as the sender sees it.
	typedef struct {
		logic [1:0]                  mode;
		logic [PlaneIdxW-1:0]        pidx;
		logic signed [NormW-1:0]     nx, ny, nz;
		logic signed [CoordW-1:0]    poff, bx, by, bz;
		logic [LenW-1:0]             rad, hgt;
		logic [ColorW-1:0]           col;
	} cull_item_t;

	// One surviving instance as it should leave the block.
	typedef struct packed {
		logic [SlotW-1:0]  slot;
		logic [CoordW-1:0] bx, by, bz;
		logic [LenW-1:0]   rad, hgt;
		logic [ColorW-1:0] col;
		logic              full;
	} kept_tree_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;

	logic [1:0]               mode;
	logic [PlaneIdxW-1:0]     plane_index;
	logic signed [NormW-1:0]  normal_x, normal_y, normal_z;
	logic signed [CoordW-1:0] plane_offset, base_x, base_y, base_z;
	logic [LenW-1:0]          radius, height;
	logic [ColorW-1:0]        color;

	logic [SlotW-1:0]         slot;
	logic signed [CoordW-1:0] out_base_x, out_base_y, out_base_z;
	logic [LenW-1:0]          out_radius, out_height;
	logic [ColorW-1:0]        out_color;
	logic                     full_res;

	// Beats waiting to be sent, and instances expected to come out, oldest first.
	cull_item_t item_q[$];
	kept_tree_t kept_q[$];

	// The beat currently on the input port. All payload ports follow it.
	cull_item_t cur_item;
	logic       beat_taken = 1'b0;

	int unsigned send_gap = 0;
	int unsigned take_gap = 0;
	bit          calm = 1'b0;
	int unsigned fails = 0;
	int unsigned cycles = 0;

	// Our own copy of the registers and of the block's state.
	logic signed [CoordW-1:0] cam_x, cam_y, cam_z;
	logic [LenW-1:0]          view_dist;
	logic [CapW-1:0]          cap_reg;
	logic signed [NormW-1:0]  pl_nx[NUM_PL], pl_ny[NUM_PL], pl_nz[NUM_PL];
	logic signed [CoordW-1:0] pl_off[NUM_PL];
	logic [CapW-1:0]          vis_count;

	assign mode         = cur_item.mode;
	assign plane_index  = cur_item.pidx;
	assign normal_x     = cur_item.nx;
	assign normal_y     = cur_item.ny;
	assign normal_z     = cur_item.nz;
	assign plane_offset = cur_item.poff;
	assign base_x       = cur_item.bx;
	assign base_y       = cur_item.by;
	assign base_z       = cur_item.bz;
	assign radius       = cur_item.rad;
	assign height       = cur_item.hgt;
	assign color        = cur_item.col;

	frustum_sphere_cull dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.plane_index  (plane_index),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.plane_offset (plane_offset),
		.base_x       (base_x),
		.base_y       (base_y),
		.base_z       (base_z),
		.radius       (radius),
		.height       (height),
		.color        (color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.out_base_x   (out_base_x),
		.out_base_y   (out_base_y),
		.out_base_z   (out_base_z),
		.out_radius   (out_radius),
		.out_height   (out_height),
		.out_color    (out_color),
		.full_res     (full_res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Applies one accepted beat to our copy of the state and, for an instance
	// that survives every test, queues the result the block must produce.
	// All sums are exact: the center is kept with one extra fraction bit so the
	// half height is exact, and the plane sums line up at 23 fraction bits.
	function automatic void cull_and_count(input cull_item_t it);
		longint eff_cap, hr, r, cx, cy, cz, dx, dy, dz, d2, md, sd;
		bit drop;
		kept_tree_t t;
		case (it.mode)
		MODE_CLEAR: vis_count = '0;
		MODE_LOAD: begin
			// Writes to plane slots that do not exist are dropped.
			if (it.pidx < NUM_PL) begin
				pl_nx[it.pidx] = it.nx;
				pl_ny[it.pidx] = it.ny;
				pl_nz[it.pidx] = it.nz;
				pl_off[it.pidx] = it.poff;
			end
		end
		MODE_TEST: begin
			// A zero register still allows one instance, and nothing above the
			// size of the visible list is honored.
			eff_cap = (cap_reg == 0) ? 1 : longint'(cap_reg);
			if (eff_cap > MAX_VIS)
				eff_cap = MAX_VIS;
			drop = (longint'(vis_count) >= eff_cap);

			// Tall instances get a sphere of 0.45 times their height.
			hr = longint'(it.hgt) * longint'(HalfRadScale) / 256;
			r = (longint'(it.rad) > hr) ? longint'(it.rad) : hr;

			cx = 2 * longint'(it.bx);
			cy = 2 * longint'(it.by) + longint'(it.hgt);
			cz = 2 * longint'(it.bz);

			dx = cx - 2 * longint'(cam_x);
			dy = cy - 2 * longint'(cam_y);
			dz = cz - 2 * longint'(cam_z);
			d2 = dx * dx + dy * dy + dz * dz;
			md = (view_dist < MinRange) ? longint'(MinRange) : longint'(view_dist);
			md = md * 2;
			if (d2 > md * md)
				drop = 1'b1;

			// A plane that was never loaded is all zero and passes everything.
			for (int i = 0; i < NUM_PL; i++) begin
				sd = longint'(pl_nx[i]) * cx + longint'(pl_ny[i]) * cy
					+ longint'(pl_nz[i]) * cz + (longint'(pl_off[i]) <<< NormShift);
				if (sd < -(r <<< NormShift))
					drop = 1'b1;
			end

			if (!drop) begin
				t.slot = vis_count[SlotW-1:0];
				vis_count = vis_count + 1'b1;
				t.bx = it.bx;
				t.by = it.by;
				t.bz = it.bz;
				t.rad = it.rad;
				t.hgt = it.hgt;
				t.col = it.col;
				t.full = (longint'(vis_count) == eff_cap);
				kept_q = {kept_q, t};
			end
		end
		default: ;
		endcase
	endfunction

	function automatic string fmt_tree(input kept_tree_t t);
		return $sformatf("slot=%0d base=(%h,%h,%h) radius=%h height=%h color=%h full=%b",
			t.slot, t.bx, t.by, t.bz, t.rad, t.hgt, t.col, t.full);
	endfunction

	// Gap lengths: mostly none, often short, now and then a long pause.
	function automatic int unsigned pick_gap();
		int unsigned roll = $urandom_range(0, 99);
		if (calm || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [CoordW-1:0] sat24(input longint v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		if (v < -64'sd8388608)
			return 24'sh800000;
		return CoordW'(v);
	endfunction

	function automatic longint rand_span(input longint span);
		return longint'($urandom_range(0, int'(2 * span))) - span;
	endfunction

	function automatic logic signed [NormW-1:0] rand_norm();
		longint v = longint'($urandom_range(0, 32768)) - 16384;
		return NormW'(v);
	endfunction

	// Every field random, the mode included; callers override what matters.
	function automatic cull_item_t scrambled();
		cull_item_t it;
		it.mode = 2'($urandom);
		it.pidx = PlaneIdxW'($urandom);
		it.nx = rand_norm();
		it.ny = rand_norm();
		it.nz = rand_norm();
		it.poff = CoordW'($urandom);
		it.bx = CoordW'($urandom);
		it.by = CoordW'($urandom);
		it.bz = CoordW'($urandom);
		it.rad = LenW'($urandom);
		it.hgt = LenW'($urandom);
		it.col = ColorW'($urandom);
		return it;
	endfunction

	function automatic cull_item_t clear_item();
		cull_item_t it = scrambled();
		it.mode = MODE_CLEAR;
		return it;
	endfunction

	function automatic cull_item_t plane_item(input logic [PlaneIdxW-1:0] idx,
			input logic signed [NormW-1:0] nx, ny, nz,
			input logic signed [CoordW-1:0] off);
		cull_item_t it = scrambled();
		it.mode = MODE_LOAD;
		it.pidx = idx;
		it.nx = nx;
		it.ny = ny;
		it.nz = nz;
		it.poff = off;
		return it;
	endfunction

	function automatic cull_item_t tree_item(input logic signed [CoordW-1:0] bx, by, bz,
			input logic [LenW-1:0] rad, hgt, input logic [ColorW-1:0] col);
		cull_item_t it = scrambled();
		it.mode = MODE_TEST;
		it.bx = bx;
		it.by = by;
		it.bz = bz;
		it.rad = rad;
		it.hgt = hgt;
		it.col = col;
		return it;
	endfunction

	function automatic longint view_reach();
		return (view_dist < MinRange) ? longint'(MinRange) : longint'(view_dist);
	endfunction

	// A plane that mostly keeps the camera on its inner side, so that the
	// instances around the camera split between kept and culled. Some planes
	// are left empty and some get an arbitrary offset.
	function automatic cull_item_t aimed_plane(input logic [PlaneIdxW-1:0] idx);
		longint dot, off, reach;
		logic signed [NormW-1:0] nx, ny, nz;
		int unsigned roll;
		reach = view_reach();
		roll = $urandom_range(0, 99);
		nx = rand_norm();
		ny = rand_norm();
		nz = rand_norm();
		if (roll < 20)
			return plane_item(idx, '0, '0, '0, '0);
		if (roll < 35)
			return plane_item(idx, nx, ny, nz, CoordW'($urandom));
		dot = longint'(nx) * cam_x + longint'(ny) * cam_y + longint'(nz) * cam_z;
		off = -(dot >>> 14) + longint'($urandom_range(0, int'(reach + reach / 4))) - reach / 4;
		return plane_item(idx, nx, ny, nz, sat24(off));
	endfunction

	// An instance placed around the camera: most inside the range, some far
	// outside it, with a few huge radii and heights.
	function automatic cull_item_t near_tree();
		longint reach, span;
		logic [LenW-1:0] rad, hgt;
		int unsigned roll;
		reach = view_reach();
		span = ($urandom_range(0, 3) == 0) ? 2 * reach : reach / 2;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			hgt = LenW'($urandom_range(0, int'(reach / 2)));
		else if (roll < 85)
			hgt = '0;
		else
			hgt = LenW'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 60)
			rad = LenW'($urandom_range(0, int'(reach / 4)));
		else if (roll < 85)
			rad = '0;
		else
			rad = LenW'($urandom);
		return tree_item(sat24(longint'(cam_x) + rand_span(span)),
			sat24(longint'(cam_y) - longint'(hgt) / 2 + rand_span(span)),
			sat24(longint'(cam_z) + rand_span(span)), rad, hgt, ColorW'($urandom));
	endfunction

	function automatic logic signed [CoordW-1:0] rand_cam();
		if ($urandom_range(0, 1) == 0)
			return sat24(rand_span(1 << 16));
		return CoordW'($urandom);
	endfunction

	function automatic logic [CfgDataW-1:0] pick_capacity();
		int unsigned roll = $urandom_range(0, 3);
		if (roll < 2)
			return CfgDataW'($urandom_range(1, 30));
		if (roll == 2)
			return CfgDataW'(MAX_VIS);
		return CfgDataW'($urandom_range(0, 131071));
	endfunction

	// Appends one beat to the end of the send queue.
	task automatic queue_item(input cull_item_t it);
		item_q = {item_q, it};
	endtask

	// Register writes go out on the falling edge and land on the next rising
	// one. They are only issued while the pipeline is empty.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		REG_CAMERA_X: cam_x = val;
		REG_CAMERA_Y: cam_y = val;
		REG_CAMERA_Z: cam_z = val;
		REG_VIEW_DIST: view_dist = val[LenW-1:0];
		REG_CAPACITY: cap_reg = val[CapW-1:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Holds the caller until every queued beat is taken and every
	// expected instance has come out, then lets the pipeline run empty.
	task automatic drain_wait();
		while (item_q.size() != 0 || in_valid || kept_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Sender. A new beat is presented on the falling edge once the previous
	// one has been taken, after an optional gap; a presented beat is held
	// untouched until the block takes it.
	always @(negedge clk) begin
		if (!arst_n || (in_valid && !beat_taken)) begin
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap = send_gap - 1;
		end else if (item_q.size() > 0) begin
			cur_item = item_q.pop_front();
			in_valid <= 1'b1;
			send_gap = pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver back pressure, independent of what the block is doing.
	always @(negedge clk) begin
		if (take_gap > 0) begin
			out_ready <= 1'b0;
			take_gap = take_gap - 1;
		end else begin
			out_ready <= 1'b1;
			take_gap = pick_gap();
		end
	end

	// Monitor. Input beats update the prediction at the edge that takes them;
	// output beats are checked against the oldest expected instance.
	always @(posedge clk) begin
		kept_tree_t got, want;
		beat_taken <= in_valid && in_ready;
		if (out_valid && out_ready) begin
			got = '{slot, out_base_x, out_base_y, out_base_z, out_radius, out_height,
				out_color, full_res};
			if (kept_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected output beat: %s", fmt_tree(got));
			end else begin
				want = kept_q.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= 10)
						$display("mismatch\n  expected %s\n  actual   %s",
							fmt_tree(want), fmt_tree(got));
				end
			end
		end
		if (in_valid && in_ready)
			cull_and_count(cur_item);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		cull_item_t it;
		int unsigned counted, roll;
		logic signed [CoordW-1:0] cx_set, cy_set, cz_set;
		logic [CfgDataW-1:0] vd_set, cap_set;

		cur_item = '{default: '0};
		cam_x = '0;
		cam_y = '0;
		cam_z = '0;
		view_dist = ViewDistReset;
		cap_reg = CapacityReset;
		vis_count = '0;
		for (int i = 0; i < NUM_PL; i++) begin
			pl_nx[i] = '0;
			pl_ny[i] = '0;
			pl_nz[i] = '0;
			pl_off[i] = '0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, with the registers at their reset values: camera at
		// the origin, a range of 256.0 and the full capacity.
		// With every plane empty, an instance at the camera is kept.
		queue_item(tree_item('0, '0, '0, LenW'(256), '0, '0));
		// The unused mode does nothing.
		it = scrambled();
		it.mode = ModeUnused;
		queue_item(it);
		// Loads past the last plane would cull everything if they took effect.
		queue_item(plane_item(PlaneIdxW'(NUM_PL), 16'sd16384, '0, '0, 24'sh800000));
		queue_item(plane_item(PlaneIdxW'(NUM_PL + 1), 16'sd16384, '0, '0, 24'sh800000));
		// Largest radius with the brightest color, then far-away extremes.
		queue_item(tree_item('0, '0, '0, '1, '0, '1));
		queue_item(tree_item(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, '1, '1, '1));
		queue_item(tree_item(24'sh800000, 24'sh800000, 24'sh800000, '0, '0, '0));
		// A huge height lifts the center far out of range.
		queue_item(tree_item('0, '0, '0, '0, '1, '1));
		// Plane x >= 0: an instance touching it exactly is kept, one step
		// further out is culled.
		queue_item(plane_item('0, 16'sd16384, '0, '0, '0));
		queue_item(tree_item(-24'sd256, '0, '0, LenW'(256), '0, ColorW'(24'h5A5A5A)));
		queue_item(tree_item(-24'sd257, '0, '0, LenW'(256), '0, ColorW'(24'hA5A5A5)));
		// Zero radius, but the height widens the sphere enough to reach.
		queue_item(tree_item(-24'sd384, '0, '0, '0, LenW'(1024), ColorW'(24'h123456)));
		queue_item(tree_item(-24'sd512, '0, '0, '0, LenW'(1024), ColorW'(24'h654321)));
		// Exactly at the view range is still inside; one step beyond is not.
		queue_item(tree_item(24'sd65536, '0, '0, '0, '0, '0));
		queue_item(tree_item(24'sd65537, '0, '0, '0, '0, '0));
		// Planes with a normal of -1.0, one with the largest offset and one with zero.
		queue_item(plane_item(PlaneIdxW'(NUM_PL - 1), '0, -16'sd16384, '0, 24'sh7FFFFF));
		queue_item(plane_item(PlaneIdxW'(1), '0, '0, -16'sd16384, '0));
		queue_item(tree_item('0, '0, '0, '0, '0, ColorW'(24'h00FF00)));
		// A new frame starts counting from slot zero again.
		queue_item(clear_item());
		queue_item(tree_item('0, '0, '0, LenW'(128), LenW'(64), ColorW'(24'hFF0000)));
		queue_item(plane_item('0, '0, '0, '0, '0));
		drain_wait();

		// Random part, one register setting per phase. The first phases hit
		// the extremes of the registers; the last ones pick them at random.
		for (int ph = 0; ph < NumPhases; ph++) begin
			calm = (ph % 4 == 3);
			cx_set = rand_cam();
			cy_set = rand_cam();
			cz_set = rand_cam();
			if ($urandom_range(0, 3) == 0)
				vd_set = CfgDataW'($urandom);
			else
				vd_set = CfgDataW'($urandom_range(256, 1 << 18));
			cap_set = pick_capacity();
			case (ph)
			0: begin
				cx_set = 24'sh7FFFFF;
				cy_set = 24'sh800000;
				vd_set = '1;
				cap_set = '1;
			end
			1: begin
				cx_set = '0;
				cy_set = '0;
				cz_set = '0;
				vd_set = '0;
				cap_set = '0;
			end
			2: begin
				vd_set = CfgDataW'(255);
				cap_set = CfgDataW'(1);
			end
			3: begin
				vd_set = CfgDataW'(256);
				cap_set = CfgDataW'(2);
			end
			4: cap_set = CfgDataW'(20);
			5: cap_set = CfgDataW'(3);
			default: ;
			endcase
			write_reg(REG_CAMERA_X, cx_set);
			write_reg(REG_CAMERA_Y, cy_set);
			write_reg(REG_CAMERA_Z, cz_set);
			write_reg(REG_VIEW_DIST, vd_set);
			write_reg(REG_CAPACITY, cap_set);

			// Phase 5 keeps the count of the frame before it, so a capacity
			// lowered below that count drops instances until the next clear.
			if (ph != 5 && $urandom_range(0, 3) != 0)
				queue_item(clear_item());
			for (int i = 0; i < NUM_PL; i++)
				queue_item(aimed_plane(PlaneIdxW'(i)));

			counted = 0;
			while (counted < ItemsPerPhase) begin
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					it = scrambled();
					it.mode = ModeUnused;
				end else if (roll < 9) begin
					it = aimed_plane('0);
					it.pidx = PlaneIdxW'($urandom_range(NUM_PL, (1 << PlaneIdxW) - 1));
				end else if (roll < 15) begin
					it = clear_item();
					counted++;
				end else if (roll < 22) begin
					it = aimed_plane(PlaneIdxW'($urandom_range(0, NUM_PL - 1)));
					counted++;
				end else if (roll < 30) begin
					it = scrambled();
					it.mode = MODE_TEST;
					counted++;
				end else begin
					it = near_tree();
					counted++;
				end
				queue_item(it);
			end
			drain_wait();
		end

		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
